// ===== src/glu_pkg.sv =====
package glu_pkg;

    // width of the operand and result fields on the ports
    localparam int OPERAND_W = 64;

    // operation codes
    localparam logic CMD_GCD = 1'b0;
    localparam logic CMD_LCM = 1'b1;

    // input word
    typedef struct packed {
        logic                        cmd;
        logic signed [OPERAND_W-1:0] first_operand;
        logic signed [OPERAND_W-1:0] second_operand;
    } t_in_word;

    // output word
    typedef struct packed {
        logic [OPERAND_W-1:0] result;
        logic                 overflow;
    } t_out_word;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic gcd_step;
        logic compose;
        logic div_init;
        logic div_step;
        logic mul_init;
        logic mul_step;
        logic emit;
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic gcd_done;
        logic is_lcm;
        logic g_zero;
    } t_dp_sts;

endpackage

// ===== src/glu_dp.sv =====
module glu_dp #(
    parameter int DATA_WIDTH = 64
) (
    input  logic              i_clk,
    input  glu_pkg::t_in_word i_in_word,
    input  glu_pkg::t_dp_cmd  i_cmd,
    output glu_pkg::t_dp_sts  o_sts,
    output glu_pkg::t_out_word o_out_word
);
    import glu_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int KW = $clog2(DATA_WIDTH);

    logic [W-1:0]   r_ma, r_mb, r_u, r_v, r_g;
    logic [KW-1:0]  r_k;
    logic [2*W-1:0] r_prod;
    logic           r_cmd;
    t_out_word      r_out;

    logic [W-1:0]   a_raw, b_raw, a_mag, b_mag;
    logic [W:0]     div_trial;
    logic [W:0]     mul_sum;
    logic [W-1:0]   res_val;
    logic           res_ovf;

    // magnitudes of the low bits of each operand
    assign a_raw = i_in_word.first_operand[W-1:0];
    assign b_raw = i_in_word.second_operand[W-1:0];
    assign a_mag = a_raw[W-1] ? (~a_raw + W'(1)) : a_raw;
    assign b_mag = b_raw[W-1] ? (~b_raw + W'(1)) : b_raw;

    // restoring divide trial and shift-add multiply partial sum
    assign div_trial = {r_v, r_u[W-1]} - {1'b0, r_g};
    assign mul_sum   = {1'b0, r_prod[2*W-1:W]} + {1'b0, (r_prod[0] ? r_mb : {W{1'b0}})};

    // status back to the controller
    assign o_sts.gcd_done = (r_u == '0) || (r_v == '0);
    assign o_sts.is_lcm   = (r_cmd == CMD_LCM);
    assign o_sts.g_zero   = (r_g == '0);

    // final value selection
    always_comb begin
        if (r_cmd == CMD_GCD) begin
            res_val = r_g;
            res_ovf = r_g[W-1];
        end else if (r_g == '0) begin
            res_val = '0;
            res_ovf = 1'b0;
        end else begin
            res_val = r_prod[W-1:0];
            res_ovf = |r_prod[2*W-1:W-1];
        end
    end

    // operand, gcd, divide and multiply registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ma  <= a_mag;
            r_mb  <= b_mag;
            r_u   <= a_mag;
            r_v   <= b_mag;
            r_k   <= '0;
            r_cmd <= i_in_word.cmd;
        end else if (i_cmd.gcd_step) begin
            // binary gcd step
            if (!r_u[0] && !r_v[0]) begin
                r_u <= r_u >> 1;
                r_v <= r_v >> 1;
                r_k <= r_k + KW'(1);
            end else if (!r_u[0]) begin
                r_u <= r_u >> 1;
            end else if (!r_v[0]) begin
                r_v <= r_v >> 1;
            end else if (r_u >= r_v) begin
                r_u <= r_u - r_v;
            end else begin
                r_v <= r_v - r_u;
            end
        end else if (i_cmd.compose) begin
            r_g <= (r_u | r_v) << r_k;
        end else if (i_cmd.div_init) begin
            r_u <= r_ma;
            r_v <= '0;
        end else if (i_cmd.div_step) begin
            // one quotient bit a cycle, remainder in r_v
            if (!div_trial[W]) begin
                r_v <= div_trial[W-1:0];
            end else begin
                r_v <= {r_v[W-2:0], r_u[W-1]};
            end
            r_u <= {r_u[W-2:0], ~div_trial[W]};
        end else if (i_cmd.mul_init) begin
            r_prod <= {{W{1'b0}}, r_u};
        end else if (i_cmd.mul_step) begin
            r_prod <= {mul_sum, r_prod[W-1:1]};
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.result   <= OPERAND_W'(res_val);
            r_out.overflow <= res_ovf;
        end
    end

    assign o_out_word = r_out;

endmodule

// ===== src/glu_ctrl.sv =====
module glu_ctrl #(
    parameter int DATA_WIDTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  glu_pkg::t_dp_sts i_sts,
    output glu_pkg::t_dp_cmd o_cmd
);
    import glu_pkg::*;

    localparam int CW = $clog2(DATA_WIDTH);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_GCD     = 3'd1;
    localparam logic [2:0] ST_COMPOSE = 3'd2;
    localparam logic [2:0] ST_SEL     = 3'd3;
    localparam logic [2:0] ST_DIV     = 3'd4;
    localparam logic [2:0] ST_MULI    = 3'd5;
    localparam logic [2:0] ST_MUL     = 3'd6;
    localparam logic [2:0] ST_DONE    = 3'd7;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_out_valid, n_out_valid;
    logic          last_iter, out_free;

    assign last_iter = (r_cnt == CW'(DATA_WIDTH - 1));
    assign out_free  = !r_out_valid || !i_out_stall;

    // next state and datapath commands
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_GCD;
                end
            end
            ST_GCD: begin
                if (i_sts.gcd_done) begin
                    n_state = ST_COMPOSE;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            ST_COMPOSE: begin
                o_cmd.compose = 1'b1;
                n_state       = ST_SEL;
            end
            ST_SEL: begin
                if (i_sts.is_lcm && !i_sts.g_zero) begin
                    o_cmd.div_init = 1'b1;
                    n_cnt          = '0;
                    n_state        = ST_DIV;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + CW'(1);
                if (last_iter) begin
                    n_state = ST_MULI;
                end
            end
            ST_MULI: begin
                o_cmd.mul_init = 1'b1;
                n_cnt          = '0;
                n_state        = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_cnt          = r_cnt + CW'(1);
                if (last_iter) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // wait for the output register to free up
                if (out_free) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // no word is taken while reset is held
    assign o_in_stall  = !i_rst_n || (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== src/gcd_lcm_unit.sv =====
// gcd / lcm unit
// input channel: i_in_valid, o_in_stall, i_in_word (cmd, first_operand,
// second_operand). a word is taken when i_in_valid is high and o_in_stall low.
// output channel: o_out_valid, i_out_stall, o_out_word (result, overflow).
// the operands are the low DATA_WIDTH bits of each field, two's complement;
// the unit answers the gcd (cmd 0) or lcm (cmd 1) of their magnitudes.
// one word is worked on at a time. the gcd is found by a binary gcd loop of
// one shift or one subtract a cycle; an lcm then adds a restoring divide and
// a shift-add multiply. the result sits in an output register: a new word is
// taken as soon as the previous one is handed to that register, even while the
// receiver stalls; if the register is still full when the next result is
// ready, the unit waits. reset (synchronous, active low) drops any word in
// flight and clears o_out_valid; o_in_stall is high while reset is held and
// a word can be taken at the first edge after reset is released.
module gcd_lcm_unit #(
    parameter int DATA_WIDTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  glu_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output glu_pkg::t_out_word o_out_word
);
    import glu_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // sequencing
    glu_ctrl #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    // arithmetic
    glu_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_in_word  (i_in_word),
        .i_cmd      (dp_cmd),
        .o_sts      (dp_sts),
        .o_out_word (o_out_word)
    );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

    import glu_pkg::*;

    // run pacing and limits
    localparam int unsigned ITEMS_PER_PHASE = 345;
    localparam int unsigned DRAIN_CYCLES    = 6 * OPERAND_W + 16;
    localparam int unsigned STALL_LIMIT     = 20000;

    localparam logic [OPERAND_W-1:0] MAX_POS = {1'b0, {(OPERAND_W-1){1'b1}}};
    localparam logic [OPERAND_W-1:0] MIN_NEG = {1'b1, {(OPERAND_W-1){1'b0}}};

    logic       i_clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    t_in_word   in_word = '0;
    logic       out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_word  o_out_word;

    // expected answers, oldest first
    t_out_word  pending_answers[$];
    t_out_word  expected_word;

    int unsigned idle_in_pct  = 0;
    int unsigned stall_pct    = 0;
    int unsigned n_errors     = 0;
    int unsigned n_gcd_words  = 0;
    int unsigned n_lcm_words  = 0;
    int unsigned n_checked    = 0;
    int unsigned n_overflows  = 0;
    int unsigned quiet_cycles = 0;

    gcd_lcm_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (o_out_word)
    );

    // clock
    always #1 i_clk = ~i_clk;

    // gcd by euclid, lcm as |a| / gcd * |b|, low bits kept on overflow
    function automatic t_out_word compute_gcd_lcm(t_in_word w);
        logic [OPERAND_W-1:0] mag_a;
        logic [OPERAND_W-1:0] mag_b;
        logic [OPERAND_W-1:0] x;
        logic [OPERAND_W-1:0] y;
        logic [OPERAND_W-1:0] rem;
        logic [OPERAND_W-1:0] quot;
        t_out_word            ans;
        mag_a = w.first_operand;
        mag_b = w.second_operand;
        if (mag_a[OPERAND_W-1]) begin
            mag_a = -mag_a;
        end
        if (mag_b[OPERAND_W-1]) begin
            mag_b = -mag_b;
        end
        x = mag_a;
        y = mag_b;
        while (y != '0) begin
            rem = x % y;
            x   = y;
            y   = rem;
        end
        if (w.cmd == CMD_GCD) begin
            ans.result   = x;
            ans.overflow = (x > MAX_POS);
        end else if (x == '0) begin
            ans.result   = '0;
            ans.overflow = 1'b0;
        end else begin
            quot         = mag_a / x;
            ans.result   = quot * mag_b;
            ans.overflow = (mag_b != '0) && (quot > MAX_POS / mag_b);
        end
        return ans;
    endfunction

    function automatic t_in_word mk_word(logic cmd, logic [OPERAND_W-1:0] a,
                                         logic [OPERAND_W-1:0] b);
        t_in_word w;
        w.cmd            = cmd;
        w.first_operand  = a;
        w.second_operand = b;
        return w;
    endfunction

    // random operand pairs: shared factors, small, full width, near limits, specials
    function automatic t_in_word make_random_word();
        logic [OPERAND_W-1:0] a;
        logic [OPERAND_W-1:0] b;
        logic [OPERAND_W-1:0] f;
        logic [OPERAND_W-1:0] tmp;
        logic [OPERAND_W-1:0] specials[5];
        int unsigned          pick;
        int unsigned          k;
        specials[0] = '0;
        specials[1] = 64'd1;
        specials[2] = '1;
        specials[3] = MIN_NEG;
        specials[4] = MAX_POS;
        pick = $urandom_range(99);
        if (pick < 30) begin
            k = $urandom_range(20);
            f = 64'($urandom_range(1, 1 << k));
            a = f * 64'($urandom_range(0, 1 << 20));
            b = f * 64'($urandom_range(0, 1 << 20));
        end else if (pick < 55) begin
            k = $urandom_range(1, 16);
            a = 64'($urandom_range(0, (1 << k) - 1));
            b = 64'($urandom_range(0, (1 << k) - 1));
        end else if (pick < 80) begin
            a = {$urandom, $urandom};
            b = {$urandom, $urandom};
        end else if (pick < 90) begin
            a = MAX_POS - 64'($urandom_range(15));
            b = 64'd1 << $urandom_range(OPERAND_W - 1);
        end else begin
            a = specials[$urandom_range(4)];
            b = $urandom_range(1) ? specials[$urandom_range(4)] : {$urandom, $urandom};
        end
        if ($urandom_range(1)) begin
            a = -a;
        end
        if ($urandom_range(1)) begin
            b = -b;
        end
        if ($urandom_range(1)) begin
            tmp = a;
            a   = b;
            b   = tmp;
        end
        return mk_word(logic'($urandom_range(1)), a, b);
    endfunction

    // send one word, entered and left at a rising edge with valid kept high
    task automatic send_word(input t_in_word w);
        logic taken;
        while ($urandom_range(99) < idle_in_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end while (!taken);
        pending_answers.push_back(compute_gcd_lcm(w));
        if (w.cmd == CMD_GCD) begin
            n_gcd_words++;
        end else begin
            n_lcm_words++;
        end
    endtask

    task automatic run_random_words(input int unsigned count);
        repeat (count) begin
            send_word(make_random_word());
        end
    endtask

    // zeros, extreme magnitudes and overflow boundaries for both operations
    task automatic test_corner_operands();
        idle_in_pct = 0;
        stall_pct   = 0;
        send_word(mk_word(CMD_GCD, '0, '0));
        send_word(mk_word(CMD_LCM, '0, '0));
        send_word(mk_word(CMD_GCD, '0, -64'd5));
        send_word(mk_word(CMD_LCM, 64'd7, '0));
        send_word(mk_word(CMD_GCD, MIN_NEG, '0));
        send_word(mk_word(CMD_GCD, MIN_NEG, MIN_NEG));
        send_word(mk_word(CMD_LCM, MIN_NEG, MIN_NEG));
        send_word(mk_word(CMD_GCD, MIN_NEG, 64'd6));
        send_word(mk_word(CMD_LCM, MIN_NEG, 64'd3));
        send_word(mk_word(CMD_GCD, MAX_POS, MAX_POS));
        send_word(mk_word(CMD_LCM, MAX_POS, MAX_POS - 1));
        send_word(mk_word(CMD_LCM, MAX_POS, 64'd1));
        send_word(mk_word(CMD_LCM, -64'd1, MAX_POS));
        send_word(mk_word(CMD_GCD, '1, '1));
        send_word(mk_word(CMD_GCD, 64'd48, -64'd18));
        send_word(mk_word(CMD_LCM, -64'd4, 64'd6));
        send_word(mk_word(CMD_GCD, 64'd7540113804746346429, 64'd4660046610375530309));
        send_word(mk_word(CMD_LCM, 64'd1 << 32, (64'd1 << 31) - 1));
        send_word(mk_word(CMD_LCM, 64'd1 << 62, 64'd2));
        send_word(mk_word(CMD_LCM, 64'd1 << 62, -64'd3));
    endtask

    task automatic test_streaming();
        idle_in_pct = 0;
        stall_pct   = 0;
        run_random_words(ITEMS_PER_PHASE);
    endtask

    task automatic test_sender_gaps();
        idle_in_pct = 55;
        stall_pct   = 0;
        run_random_words(ITEMS_PER_PHASE);
    endtask

    task automatic test_receiver_stalls();
        idle_in_pct = 0;
        stall_pct   = 55;
        run_random_words(ITEMS_PER_PHASE);
    endtask

    task automatic test_mixed_pacing();
        idle_in_pct = 17;
        stall_pct   = 17;
        run_random_words(ITEMS_PER_PHASE);
    endtask

    // receiver back-pressure
    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // result checker, sampled mid-cycle so the coming edge decides the handshake
    always @(negedge i_clk) begin
        if (rst_n && o_out_valid && !out_stall) begin
            if (pending_answers.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected word: expected none, actual result %h overflow %b",
                         $realtime, o_out_word.result, o_out_word.overflow);
            end else begin
                expected_word = pending_answers.pop_front();
                n_checked++;
                if (expected_word.overflow) begin
                    n_overflows++;
                end
                if (o_out_word.result !== expected_word.result) begin
                    n_errors++;
                    $display("%0t: result mismatch: expected %h actual %h",
                             $realtime, expected_word.result, o_out_word.result);
                end
                if (o_out_word.overflow !== expected_word.overflow) begin
                    n_errors++;
                    $display("%0t: overflow mismatch: expected %b actual %b",
                             $realtime, expected_word.overflow, o_out_word.overflow);
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(negedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: %0d words still awaited", pending_answers.size());
            $display("FAIL gcd_lcm_unit");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // reset, tests in turn, drain and verdict
    initial begin
        repeat (5) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        test_corner_operands();
        test_streaming();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_pacing();
        in_valid <= 1'b0;
        while (pending_answers.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("checked %0d results: %0d gcd and %0d lcm words, %0d overflowing",
                 n_checked, n_gcd_words, n_lcm_words, n_overflows);
        $display("pacing: free flow, sender gaps, receiver stalls and both mixed");
        if (n_errors == 0) begin
            $display("PASS gcd_lcm_unit");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("FAIL gcd_lcm_unit");
        end
        $finish;
    end

endmodule

// ===== gcd_lcm_unit.f =====
src/glu_pkg.sv
src/glu_dp.sv
src/glu_ctrl.sv
src/gcd_lcm_unit.sv
verif/tb.sv
